FILE: src/rdp_pkg.sv
// Shared types, codes and helper functions for the truecolor RAMDAC register port.
package rdp_pkg;

    localparam int PLL_ENTRIES = 16;
    localparam int PLL_IDX_W   = $clog2(PLL_ENTRIES);

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [2:0] SEL_WADDR    = 3'd0;
    localparam logic [2:0] SEL_DATA     = 3'd1;
    localparam logic [2:0] SEL_MASK     = 3'd2;
    localparam logic [2:0] SEL_RADDR    = 3'd3;
    localparam logic [2:0] SEL_PLL_WIDX = 3'd4;
    localparam logic [2:0] SEL_PLL_DATA = 3'd5;
    localparam logic [2:0] SEL_CMD      = 3'd6;
    localparam logic [2:0] SEL_PLL_RIDX = 3'd7;

    localparam logic [7:0] HIDDEN_ID        = 8'h70;
    localparam logic [2:0] HIDDEN_ID_COUNT  = 3'd4;
    localparam logic [2:0] HIDDEN_CMD_COUNT = 3'd5;

    localparam logic [2:0] DEPTH_8  = 3'd0;
    localparam logic [2:0] DEPTH_15 = 3'd1;
    localparam logic [2:0] DEPTH_16 = 3'd2;
    localparam logic [2:0] DEPTH_24 = 3'd3;
    localparam logic [2:0] DEPTH_32 = 3'd4;

    localparam logic [15:0] PLL_RESET_0 = 16'h6128;
    localparam logic [15:0] PLL_RESET_1 = 16'h623d;

    typedef struct packed {
        logic       operation;
        logic [2:0] reg_select;
        logic [7:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       pass_through;
        logic [2:0] pixel_depth;
    } t_out_item;

    function automatic logic [2:0] depth_code(input logic [7:0] cmd);
        logic [2:0] d;
        case (cmd[7:4])
            4'h2, 4'h3, 4'h8, 4'ha: d = DEPTH_15;
            4'h5, 4'h6, 4'hc:       d = DEPTH_16;
            4'h4, 4'h9, 4'he:       d = DEPTH_24;
            4'h7:                   d = DEPTH_32;
            default:                d = DEPTH_8;
        endcase
        return d;
    endfunction

    function automatic logic word_writable(input logic [7:0] idx);
        return ((idx >= 8'd2) && (idx <= 8'd7)) || (idx == 8'd10) || (idx == 8'd14);
    endfunction

    function automatic logic index_in_range(input logic [7:0] idx);
        return {1'b0, idx} < 9'(PLL_ENTRIES);
    endfunction

    function automatic logic [15:0] pll_reset_word(input int i);
        logic [15:0] w;
        if (i == 0) begin
            w = PLL_RESET_0;
        end else if (i == 1) begin
            w = PLL_RESET_1;
        end else begin
            w = 16'h0000;
        end
        return w;
    endfunction

endpackage

FILE: src/truecolor_ramdac_register_port.sv
// Top level of the truecolor RAMDAC register port with input and result registers.
// An accepted access moves from the input register to the result register.
// Throughput: one access per cycle unless stalled; single registered state update.
// The input register takes a new transfer whenever the result register can move.
// Reset (synchronous, active low) clears the command, hidden counter, indices and
// byte phase, and loads the PLL words with their power-on values.
module truecolor_ramdac_register_port (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  rdp_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output rdp_pkg::t_out_item o_out_item
);

    logic               r_in_valid;
    rdp_pkg::t_in_item  r_in_item;
    logic               r_out_valid;
    rdp_pkg::t_out_item r_out_item;

    logic               advance;
    logic               fire;
    rdp_pkg::t_out_item result;

    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    rdp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in_item),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
                if (i_in_valid) begin
                    r_in_item <= i_in_item;
                end
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
                if (fire) begin
                    r_out_item <= result;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef NO_ASSERTIONS
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_valid && i_out_stall))
        else $error("Input stalled without a stalled result.");

    a_fire_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_out_valid)
        else $error("Processed access produced no result.");

    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.pixel_depth <= rdp_pkg::DEPTH_32))
        else $error("Pixel depth code out of range.");

    a_pass_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.pass_through) |-> (o_out_item.read_data == 8'h00))
        else $error("Pass-through transfer returned nonzero read data.");
`endif

endmodule

FILE: src/rdp_core.sv
// Register state, PLL word bank and access decode of the RAMDAC register port.
module rdp_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  rdp_pkg::t_in_item i_item,
    output rdp_pkg::t_out_item o_result
);

    logic [7:0]  r_command;
    logic [2:0]  r_hidden_count;
    logic [7:0]  r_write_index;
    logic [7:0]  r_read_index;
    logic        r_high_phase;
    logic [15:0] r_pll [rdp_pkg::PLL_ENTRIES];

    logic [7:0]  n_command;
    logic [2:0]  n_hidden_count;
    logic [7:0]  n_write_index;
    logic [7:0]  n_read_index;
    logic        n_high_phase;

    logic        pll_we;
    logic [15:0] pll_wdata;
    logic [15:0] pll_wcur;
    logic [15:0] pll_rword;
    logic [2:0]  hidden_inc;
    logic [7:0]  data;
    logic        pass;

    assign pll_wcur  = r_pll[r_write_index[rdp_pkg::PLL_IDX_W-1:0]];
    assign pll_rword = r_pll[r_read_index[rdp_pkg::PLL_IDX_W-1:0]];
    assign pll_wdata = r_high_phase ? {i_item.write_data, pll_wcur[7:0]}
                                    : {pll_wcur[15:8], i_item.write_data};
    assign hidden_inc = (r_hidden_count < rdp_pkg::HIDDEN_CMD_COUNT)
                        ? r_hidden_count + 3'd1 : r_hidden_count;

    always_comb begin
        n_command      = r_command;
        n_hidden_count = r_hidden_count;
        n_write_index  = r_write_index;
        n_read_index   = r_read_index;
        n_high_phase   = r_high_phase;
        pll_we         = 1'b0;
        data           = 8'h00;
        pass           = 1'b0;
        if (i_item.operation == rdp_pkg::OP_WRITE) begin
            pass = 1'b1;
            case (i_item.reg_select)
                rdp_pkg::SEL_MASK: begin
                    if (r_hidden_count == rdp_pkg::HIDDEN_ID_COUNT) begin
                        n_command = i_item.write_data;
                    end
                    n_hidden_count = 3'd0;
                end
                rdp_pkg::SEL_WADDR, rdp_pkg::SEL_DATA, rdp_pkg::SEL_RADDR: begin
                    n_hidden_count = 3'd0;
                end
                rdp_pkg::SEL_PLL_WIDX: begin
                    n_write_index = i_item.write_data;
                    n_high_phase  = 1'b0;
                end
                rdp_pkg::SEL_PLL_DATA: begin
                    pll_we = rdp_pkg::index_in_range(r_write_index)
                             && rdp_pkg::word_writable(r_write_index);
                    n_high_phase = ~r_high_phase;
                    if (r_high_phase) begin
                        n_write_index = r_write_index + 8'd1;
                    end
                end
                rdp_pkg::SEL_CMD: begin
                    n_command = i_item.write_data;
                end
                rdp_pkg::SEL_PLL_RIDX: begin
                    n_read_index = i_item.write_data;
                    n_high_phase = 1'b0;
                end
                default: begin
                    n_hidden_count = 3'd0;
                end
            endcase
        end else begin
            case (i_item.reg_select)
                rdp_pkg::SEL_MASK: begin
                    if (hidden_inc == rdp_pkg::HIDDEN_ID_COUNT) begin
                        n_hidden_count = hidden_inc;
                        data           = rdp_pkg::HIDDEN_ID;
                    end else if (hidden_inc == rdp_pkg::HIDDEN_CMD_COUNT) begin
                        n_hidden_count = 3'd0;
                        data           = r_command;
                    end else begin
                        n_hidden_count = hidden_inc;
                        pass           = 1'b1;
                    end
                end
                rdp_pkg::SEL_WADDR, rdp_pkg::SEL_DATA, rdp_pkg::SEL_RADDR: begin
                    n_hidden_count = 3'd0;
                    pass           = 1'b1;
                end
                rdp_pkg::SEL_PLL_WIDX: begin
                    data = r_write_index;
                end
                rdp_pkg::SEL_PLL_DATA: begin
                    if (rdp_pkg::index_in_range(r_read_index)) begin
                        data = r_high_phase ? pll_rword[15:8] : pll_rword[7:0];
                    end
                    n_high_phase = ~r_high_phase;
                    if (r_high_phase) begin
                        n_read_index = r_read_index + 8'd1;
                    end
                end
                rdp_pkg::SEL_CMD: begin
                    data = r_command;
                end
                rdp_pkg::SEL_PLL_RIDX: begin
                    data = r_read_index;
                end
                default: begin
                    n_hidden_count = 3'd0;
                    pass           = 1'b1;
                end
            endcase
        end
    end

    assign o_result.read_data    = data;
    assign o_result.pass_through = pass;
    assign o_result.pixel_depth  = rdp_pkg::depth_code(n_command);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_command      <= 8'h00;
            r_hidden_count <= 3'd0;
            r_write_index  <= 8'h00;
            r_read_index   <= 8'h00;
            r_high_phase   <= 1'b0;
            for (int i = 0; i < rdp_pkg::PLL_ENTRIES; i++) begin
                r_pll[i] <= rdp_pkg::pll_reset_word(i);
            end
        end else if (i_fire) begin
            r_command      <= n_command;
            r_hidden_count <= n_hidden_count;
            r_write_index  <= n_write_index;
            r_read_index   <= n_read_index;
            r_high_phase   <= n_high_phase;
            if (pll_we) begin
                r_pll[r_write_index[rdp_pkg::PLL_IDX_W-1:0]] <= pll_wdata;
            end
        end
    end

endmodule
